// File: rtl/core/fpjb_pkg.sv
// Shared constants for the flash page journal bitmaps block.
`timescale 1ns / 1ps
`default_nettype none

package fpjb_pkg;

   // Bits in one bitmap word and the page-to-word shift
   localparam int WORD_BITS  = 32;
   localparam int WORD_SHIFT = 5;

   // Input field widths
   localparam int MODE_W  = 2;
   localparam int START_W = 20;
   localparam int COUNT_W = 11;
   localparam int LEN_W   = 21;

   // Byte end address of a query: start + length needs one more bit than length
   localparam int SUM_W = LEN_W + 1;

   // Operation codes
   localparam logic [MODE_W-1:0] MODE_MARK_INVALID  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_MARK_COMPLETE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_QUERY         = 2'd2;
   localparam logic [MODE_W-1:0] MODE_UNUSED        = 2'd3;

   // One map word: complete flags on top, invalid flags below
   typedef struct packed {
      logic [WORD_BITS-1:0] complete;
      logic [WORD_BITS-1:0] invalid;
   } map_word_type;

endpackage

`default_nettype wire

// File: rtl/core/fpjb_map_mem.sv
// Flag map memory: one word of both bitmaps per address, erased until written.
`timescale 1ns / 1ps
`default_nettype none

module fpjb_map_mem
   import fpjb_pkg::*;
#(
   parameter int MAP_WORDS = 32,
   parameter int WA_W      = 5
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         rd_en,
   input  wire logic [WA_W-1:0] rd_addr,
   output map_word_type      rd_data,
   input  wire logic         wr_en,
   input  wire logic [WA_W-1:0] wr_addr,
   input  wire map_word_type wr_data
);

   map_word_type           mem [MAP_WORDS];
   logic [MAP_WORDS-1:0]   written_ff;
   map_word_type           rd_word_ff;
   logic                   rd_written_ff;

   // Storage array, no reset
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_word_ff    <= mem[rd_addr];
         rd_written_ff <= written_ff[rd_addr];
      end
   end

   // Per-word written flags; a word never written reads as erased
   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
      end else if (wr_en) begin
         written_ff[wr_addr] <= 1'b1;
      end
   end

   assign rd_data = rd_written_ff ? rd_word_ff : '1;

endmodule

`default_nettype wire

// File: rtl/core/fpjb_mask_unit.sv
// Page-window mask for one map word: bits whose page lies in [lo, hi).
`timescale 1ns / 1ps
`default_nettype none

module fpjb_mask_unit
   import fpjb_pkg::*;
#(
   parameter int PAGE_W = 12,
   parameter int WA_W   = 5
) (
   input  wire logic [WA_W-1:0]   word_addr,
   input  wire logic [PAGE_W-1:0] lo_page,
   input  wire logic [PAGE_W-1:0] hi_page,
   output logic [WORD_BITS-1:0]   mask
);

   logic [PAGE_W-1:0] base_page;

   assign base_page = PAGE_W'(word_addr) << WORD_SHIFT;

   // One compare pair per bit, all independent
   always_comb begin
      for (int b = 0; b < WORD_BITS; b++) begin
         logic [PAGE_W-1:0] pg;
         pg      = base_page | PAGE_W'(b);
         mask[b] = (pg >= lo_page) && (pg < hi_page);
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/flash_page_journal_bitmaps_core.sv
// Top level of the flash page journal bitmaps block: sequencer and result register.
`timescale 1ns / 1ps
`default_nettype none

// Keeps an invalid and a complete bitmap, one bit per page, erased to 1;
// marks only clear bits. One item is in work at a time: accept, a setup
// step, a walk over each 32-page map word touched by the range (at most
// MAP_WORDS), a drain step and a finish step that loads the result
// register. The walk does one read-modify-write per map word through the
// read and write ports of the map memory and the one shared mask unit. A
// mark touching no map page, a query of an empty range or of pages
// outside the map only, or an item of the unused mode skips the walk and
// drain. While the result register is full and stalled, the item stays in
// its finish step until the register frees. The result register lets the
// next item be accepted while a result waits.
// PAGE_BYTES must be a power of two. No clearing pass after reset.
module flash_page_journal_bitmaps_core
   import fpjb_pkg::*;
#(
   parameter int PAGE_BYTES = 1024,
   parameter int MAP_WORDS  = 32
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // Input channel
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [MODE_W-1:0]  req_mode,
   input  wire logic [START_W-1:0] req_start_address,
   input  wire logic [COUNT_W-1:0] req_page_count,
   input  wire logic [LEN_W-1:0]   req_byte_length,
   // Result channel
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic                    rsp_range_complete,
   output logic                    rsp_range_invalid,
   // Configuration
   input  wire logic               csr_wr_en,
   input  wire logic               csr_wr_data
);

   localparam int PG_SHIFT  = $clog2(PAGE_BYTES);
   localparam int PAGE_W    = (SUM_W - PG_SHIFT > 12) ? SUM_W - PG_SHIFT : 12;
   localparam int WA_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int MAP_PAGES = MAP_WORDS * WORD_BITS;
   localparam logic [PAGE_W-1:0] MAP_PAGES_P = PAGE_W'(MAP_PAGES);

   // Sequencer states
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SETUP  = 3'd1;
   localparam logic [2:0] ST_WALK   = 3'd2;
   localparam logic [2:0] ST_DRAIN  = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;

   logic [2:0]         state_ff, state_in;
   logic [MODE_W-1:0]  mode_ff;
   logic [PAGE_W-1:0]  lo_ff, hi_ff, hic_ff;
   logic [WA_W-1:0]    rd_ptr_ff, last_ff;
   logic               s1_valid_ff;
   logic [WA_W-1:0]    s1_addr_ff;
   logic               complete_ff, inv_hit_ff;
   logic               journal_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_complete_ff, rsp_invalid_ff;

   logic               accept;
   logic               load_rsp;
   logic [SUM_W-1:0]   end_byte;
   logic [PAGE_W-1:0]  first_page, end_page, mark_end;
   logic [PAGE_W-1:0]  hic;
   logic               walk_go;
   logic               is_mark;
   logic               mem_rd_en, mem_wr_en;
   map_word_type       mem_rd_data, mem_wr_data;
   logic [WORD_BITS-1:0] mask;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign is_mark   = (mode_ff == MODE_MARK_INVALID) || (mode_ff == MODE_MARK_COMPLETE);

   // Page bounds of the incoming item
   assign end_byte   = SUM_W'(req_start_address) + SUM_W'(req_byte_length);
   assign first_page = PAGE_W'(req_start_address >> PG_SHIFT);
   assign end_page   = PAGE_W'(end_byte >> PG_SHIFT);
   assign mark_end   = first_page + PAGE_W'(req_page_count);

   // Range clipped to the map
   assign hic     = (hi_ff > MAP_PAGES_P) ? MAP_PAGES_P : hi_ff;
   assign walk_go = (mode_ff != MODE_UNUSED) && (lo_ff < hic);

   // Sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (accept) state_in = ST_SETUP;
         ST_SETUP:  state_in = walk_go ? ST_WALK : ST_FINISH;
         ST_WALK:   if (rd_ptr_ff == last_ff) state_in = ST_DRAIN;
         ST_DRAIN:  state_in = ST_FINISH;
         ST_FINISH: if (load_rsp) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         s1_valid_ff <= 1'b0;
         journal_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         s1_valid_ff <= (state_ff == ST_WALK);
         if (csr_wr_en) begin
            journal_ff <= csr_wr_data;
         end
      end
   end

   // Item registers, walk pointer and query flags
   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff <= req_mode;
         lo_ff   <= first_page;
         hi_ff   <= (req_mode == MODE_QUERY) ? end_page : mark_end;
      end
      if (state_ff == ST_SETUP) begin
         hic_ff      <= hic;
         rd_ptr_ff   <= WA_W'(lo_ff >> WORD_SHIFT);
         last_ff     <= WA_W'((hic - PAGE_W'(1)) >> WORD_SHIFT);
         // pages past the map stay erased, so such a query is never complete
         complete_ff <= !((mode_ff == MODE_QUERY) && (hi_ff > MAP_PAGES_P) && (lo_ff < hi_ff));
         inv_hit_ff  <= 1'b0;
      end
      if (state_ff == ST_WALK) begin
         rd_ptr_ff  <= rd_ptr_ff + WA_W'(1);
         s1_addr_ff <= rd_ptr_ff;
      end
      if (s1_valid_ff && (mode_ff == MODE_QUERY)) begin
         if (|(mem_rd_data.complete & mask)) complete_ff <= 1'b0;
         if (|(~mem_rd_data.invalid & mask)) inv_hit_ff <= 1'b1;
      end
   end

   // Read-modify-write of one map word per cycle
   assign mem_rd_en = (state_ff == ST_WALK);
   assign mem_wr_en = s1_valid_ff && is_mark;

   always_comb begin
      mem_wr_data = mem_rd_data;
      if (mode_ff == MODE_MARK_INVALID) begin
         mem_wr_data.invalid = mem_rd_data.invalid & ~mask;
      end else begin
         mem_wr_data.complete = mem_rd_data.complete & ~mask;
      end
   end

   fpjb_map_mem #(
      .MAP_WORDS (MAP_WORDS),
      .WA_W      (WA_W)
   ) u_map_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (mem_rd_en),
      .rd_addr (rd_ptr_ff),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (s1_addr_ff),
      .wr_data (mem_wr_data)
   );

   fpjb_mask_unit #(
      .PAGE_W (PAGE_W),
      .WA_W   (WA_W)
   ) u_mask_unit (
      .word_addr (s1_addr_ff),
      .lo_page   (lo_ff),
      .hi_page   (hic_ff),
      .mask      (mask)
   );

   // Result register
   assign load_rsp     = (state_ff == ST_FINISH) && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid_in = load_rsp || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_complete_ff <= (mode_ff == MODE_QUERY) && complete_ff;
         rsp_invalid_ff  <= (mode_ff == MODE_QUERY) && journal_ff && inv_hit_ff
                            && !complete_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_range_complete = rsp_complete_ff;
   assign rsp_range_invalid  = rsp_invalid_ff;

endmodule

`default_nettype wire

// File: rtl/core/fpjb_checker.sv
// Port-level checks for the flash page journal bitmaps block, with bind.
`timescale 1ns / 1ps
`default_nettype none

module fpjb_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_stall,
   input wire logic rsp_valid,
   input wire logic rsp_stall,
   input wire logic rsp_range_complete,
   input wire logic rsp_range_invalid
);

   // A waiting result is not dropped
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // One item at a time: intake closes right after a transfer
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input open in the cycle after a transfer");

   // Invalid is only reported for a range that is not complete
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_range_complete && rsp_range_invalid))
      else $error("range reported both complete and invalid");

   // No result right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind flash_page_journal_bitmaps_core fpjb_checker u_fpjb_checker (.*);

`default_nettype wire
